>>> rtl/utt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utt_pkg: shared types and constants for the uuid text parser
// Character positions, hyphen slots, status codes and the structs that pass
// between the character decoder, the parse core and the top level.
// ----------------------------------------------------------------------------
package utt_pkg;

   // text layout
   localparam int unsigned POS_W = 6;
   localparam logic [POS_W-1:0] UUID_TEXT_LEN = 6'd36;
   localparam logic [POS_W-1:0] POS_SATURATE  = 6'd37;
   localparam logic [POS_W-1:0] HYPHEN_A      = 6'd8;
   localparam logic [POS_W-1:0] HYPHEN_B      = 6'd13;
   localparam logic [POS_W-1:0] HYPHEN_C      = 6'd18;
   localparam logic [POS_W-1:0] HYPHEN_D      = 6'd23;

   // character codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;
   localparam logic [7:0] DIGIT_TEN   = 8'd10;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_ZERO      = 2'd2;

   // decoded character
   typedef struct packed {
      logic       is_nul;
      logic       is_hyphen;
      logic       is_hex;
      logic [3:0] nibble;
   } char_class_type;

   // one result word
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/utt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utt_req_if / utt_rsp_if: valid/ready channels of the uuid text parser
// The request channel carries one character per word, the response channel
// carries a status and the four parsed 32-bit words.
// ----------------------------------------------------------------------------
interface utt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface utt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] word0;
   logic [31:0] word1;
   logic [31:0] word2;
   logic [31:0] word3;

   modport source (output valid, output status, output word0, output word1,
                   output word2, output word3, input ready);
   modport sink   (input valid, input status, input word0, input word1,
                   input word2, input word3, output ready);
endinterface
`default_nettype wire

>>> rtl/utt_char_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utt_char_decode: character classifier
// Flags the terminator and the hyphen and turns a hex digit of either case
// into its 4-bit value.
// ----------------------------------------------------------------------------
module utt_char_decode (
   input  wire logic [7:0]              char_code,
   output utt_pkg::char_class_type      char_class
);
   import utt_pkg::*;

   logic       is_dec;
   logic       is_up;
   logic       is_lo;
   logic [7:0] dec_val;
   logic [7:0] up_val;
   logic [7:0] lo_val;

   // range checks for the three digit groups
   assign is_dec = (char_code >= CHAR_0) && (char_code <= CHAR_9);
   assign is_up  = (char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_F);
   assign is_lo  = (char_code >= CHAR_LO_A) && (char_code <= CHAR_LO_F);

   assign dec_val = char_code - CHAR_0;
   assign up_val  = char_code - CHAR_UP_A + DIGIT_TEN;
   assign lo_val  = char_code - CHAR_LO_A + DIGIT_TEN;

   // pick the nibble value
   always_comb begin
      char_class.is_nul    = (char_code == CHAR_NUL);
      char_class.is_hyphen = (char_code == CHAR_HYPHEN);
      char_class.is_hex    = is_dec | is_up | is_lo;
      if (is_dec) begin
         char_class.nibble = dec_val[3:0];
      end else if (is_up) begin
         char_class.nibble = up_val[3:0];
      end else if (is_lo) begin
         char_class.nibble = lo_val[3:0];
      end else begin
         char_class.nibble = 4'd0;
      end
   end

endmodule
`default_nettype wire

>>> rtl/utt_parse_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utt_parse_core: parse state and result formation
// Holds the character position, the pending high nibble, the 128-bit
// accumulator and the error flag; forms the result on the terminator.
// ----------------------------------------------------------------------------
module utt_parse_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire utt_pkg::char_class_type char_class,
   output utt_pkg::result_type          result
);
   import utt_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0]       hold_ff, hold_in;
   logic [127:0]     acc_ff, acc_in;
   logic             err_ff, err_in;

   logic             hyphen_slot;
   logic [2:0]       hyphens_passed;
   logic             low_digit;
   logic             bad;

   // position classification
   assign hyphen_slot = (pos_ff == HYPHEN_A) || (pos_ff == HYPHEN_B) ||
                        (pos_ff == HYPHEN_C) || (pos_ff == HYPHEN_D);
   assign hyphens_passed = {2'b00, pos_ff > HYPHEN_A} + {2'b00, pos_ff > HYPHEN_B} +
                           {2'b00, pos_ff > HYPHEN_C} + {2'b00, pos_ff > HYPHEN_D};
   // digit index parity: odd index closes a byte
   assign low_digit = pos_ff[0] ^ hyphens_passed[0];

   // result from the state ahead of the terminator
   assign bad = err_ff || (pos_ff != UUID_TEXT_LEN);
   always_comb begin
      if (bad) begin
         result.status = STATUS_MALFORMED;
         result.word0  = '0;
         result.word1  = '0;
         result.word2  = '0;
         result.word3  = '0;
      end else begin
         result.status = (acc_ff == '0) ? STATUS_ZERO : STATUS_OK;
         result.word0  = acc_ff[127:96];
         result.word1  = acc_ff[95:64];
         result.word2  = acc_ff[63:32];
         result.word3  = acc_ff[31:0];
      end
   end

   // next state
   always_comb begin
      pos_in  = pos_ff;
      hold_in = hold_ff;
      acc_in  = acc_ff;
      err_in  = err_ff;
      if (step) begin
         if (char_class.is_nul) begin
            pos_in  = '0;
            hold_in = '0;
            acc_in  = '0;
            err_in  = 1'b0;
         end else begin
            if (pos_ff >= UUID_TEXT_LEN) begin
               err_in = 1'b1;
            end else if (hyphen_slot) begin
               if (!char_class.is_hyphen) begin
                  err_in = 1'b1;
               end
            end else if (!char_class.is_hex) begin
               err_in = 1'b1;
            end else if (!low_digit) begin
               hold_in = char_class.nibble;
            end else begin
               acc_in = {acc_ff[119:0], hold_ff, char_class.nibble};
            end
            if (pos_ff < POS_SATURATE) begin
               pos_in = pos_ff + 6'd1;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         hold_ff <= '0;
         acc_ff  <= '0;
         err_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         hold_ff <= hold_in;
         acc_ff  <= acc_in;
         err_ff  <= err_in;
      end
   end

   // position never runs past saturation
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_SATURATE)
      else $error("character position past saturation");

   // a terminator returns the parser to its start
   a_nul_clears: assert property (@(posedge clock) disable iff (reset)
      step && char_class.is_nul |=> (pos_ff == '0) && !err_ff && (acc_ff == '0))
      else $error("state not cleared after terminator");

   // text past the end always marks an error
   a_too_long: assert property (@(posedge clock) disable iff (reset)
      step && !char_class.is_nul && (pos_ff >= UUID_TEXT_LEN) |=> err_ff)
      else $error("overlong text not flagged");

   // error stays set until the terminator
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff && !(step && char_class.is_nul) |=> err_ff)
      else $error("error flag dropped early");

endmodule
`default_nettype wire

>>> rtl/uuid_text_to_words.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uuid_text_to_words: canonical uuid text parser
// Parses "xxxxxxxx-xxxx-xxxx-xxxx-xxxxxxxxxxxx" text into four 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one character per word; a zero character ends the text.
//   rsp carries one word per terminator: status (ok, malformed, all zeros)
//   and word0..word3, big-endian in text order, zero when malformed.
//   Non-terminator characters produce no response.
// Timing:
//   a character accepted into the input register is decoded there and folded
//   into the parse state; a terminator's response is loaded into the response
//   register once that slot is free, and is taken from there on rsp.ready.
//   Throughput is one character per cycle unless a terminator stalls; set by
//   the combinational decode and 128-bit shift from input to state registers.
// Stall:
//   while a response waits on rsp.ready, characters keep flowing; only a
//   further terminator holds in the input register until the response slot
//   frees, and req.ready drops once that register is blocked.
// Reset:
//   synchronous reset empties both registers and returns the parser to
//   position zero with the accumulator and error flag cleared.
// ----------------------------------------------------------------------------
module uuid_text_to_words (
   input  wire logic   clock,
   input  wire logic   reset,
   utt_req_if.sink     req,
   utt_rsp_if.source   rsp
);
   import utt_pkg::*;

   logic           s1_valid_ff, s1_valid_in;
   logic [7:0]     char_ff;
   char_class_type char_class;
   result_type     result;
   result_type     rsp_data_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           go;

   // decode the registered character
   utt_char_decode u_decode (
      .char_code  (char_ff),
      .char_class (char_class)
   );

   // parse state
   utt_parse_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (go),
      .char_class (char_class),
      .result     (result)
   );

   // flow control: only a terminator needs the response slot
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign go        = s1_valid_ff && (!char_class.is_nul || out_free);
   assign req.ready = !s1_valid_ff || go;

   // input register
   assign s1_valid_in = req.valid || (s1_valid_ff && !go);
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         char_ff <= req.char_code;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go && char_class.is_nul) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go && char_class.is_nul) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.status = rsp_data_ff.status;
   assign rsp.word0  = rsp_data_ff.word0;
   assign rsp.word1  = rsp_data_ff.word1;
   assign rsp.word2  = rsp_data_ff.word2;
   assign rsp.word3  = rsp_data_ff.word3;

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !(go && char_class.is_nul))
      else $error("response overwritten while stalled");

   // a stalled terminator holds the input register
   a_nul_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && char_class.is_nul && !out_free |=> s1_valid_ff && $stable(char_ff))
      else $error("stalled terminator lost");

   // malformed responses carry zero in word0 and word3
   a_malformed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == STATUS_MALFORMED) |->
      (rsp_data_ff.word0 == '0) && (rsp_data_ff.word3 == '0))
      else $error("malformed response carries data");

endmodule
`default_nettype wire

>>> bench/uuid_text_to_words_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uuid_text_to_words_tb: self-checking bench for the uuid text parser
// Streams canonical uuid texts, clean and damaged, one character per word and
// mirrors the parser state to predict the status and four words of each
// terminator. Both channels idle in random bursts until the tail of the run.
// ----------------------------------------------------------------------------
module uuid_text_to_words_tb;
   import utt_pkg::*;

   localparam int RANDOM_CHARS = 1100;
   localparam int MIN_TEXTS    = 16;
   localparam int QUIET_TAIL   = 150;
   localparam int DRAIN_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;

   typedef enum int {CASE_LOWER, CASE_UPPER, CASE_MIXED} letter_case_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       feed_valid  = 1'b0;
   logic [7:0] feed_char   = CHAR_NUL;
   logic       drain_ready = 1'b0;

   utt_req_if req_ch ();
   utt_rsp_if rsp_ch ();

   assign req_ch.valid     = feed_valid;
   assign req_ch.char_code = feed_char;
   assign rsp_ch.ready     = drain_ready;

   uuid_text_to_words uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   logic [7:0] char_queue[$];
   logic [7:0] text_buf[$];
   result_type expected_results[$];
   int         fail_count   = 0;
   int         quiet_cycles = 0;

   // mirror of the parse state
   logic [POS_W-1:0] text_pos       = '0;
   logic [3:0]       pending_nibble = '0;
   logic [127:0]     parsed_bits    = '0;
   logic             bad_text       = 1'b0;

   // clock and the single reset pulse
   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic is_dash_slot(input logic [POS_W-1:0] pos);
      return pos == HYPHEN_A || pos == HYPHEN_B || pos == HYPHEN_C || pos == HYPHEN_D;
   endfunction

   task automatic clear_parse();
      text_pos       = '0;
      pending_nibble = '0;
      parsed_bits    = '0;
      bad_text       = 1'b0;
   endtask

   // fold one accepted character into the mirror, queue a result on a terminator
   task automatic parse_char(input logic [7:0] c);
      result_type       r;
      logic [POS_W-1:0] digit_idx;
      logic [3:0]       nib;
      logic             hex_ok;
      r      = '0;
      nib    = '0;
      hex_ok = 1'b1;
      if (c == CHAR_NUL) begin
         if (bad_text || text_pos != UUID_TEXT_LEN) begin
            r.status = STATUS_MALFORMED;
         end else begin
            r.status = (parsed_bits == '0) ? STATUS_ZERO : STATUS_OK;
            {r.word0, r.word1, r.word2, r.word3} = parsed_bits;
         end
         expected_results.push_back(r);
         clear_parse();
      end else begin
         if (text_pos >= UUID_TEXT_LEN) begin
            bad_text = 1'b1;
         end else if (is_dash_slot(text_pos)) begin
            if (c != CHAR_HYPHEN) bad_text = 1'b1;
         end else begin
            if (c >= CHAR_0 && c <= CHAR_9) begin
               nib = 4'(c - CHAR_0);
            end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
               nib = 4'(c - CHAR_LO_A + DIGIT_TEN);
            end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
               nib = 4'(c - CHAR_UP_A + DIGIT_TEN);
            end else begin
               hex_ok = 1'b0;
            end
            // digit index skips the hyphens already passed
            digit_idx = text_pos - (text_pos > HYPHEN_A) - (text_pos > HYPHEN_B)
                        - (text_pos > HYPHEN_C) - (text_pos > HYPHEN_D);
            if (!hex_ok) begin
               bad_text = 1'b1;
            end else if (!digit_idx[0]) begin
               pending_nibble = nib;
            end else begin
               parsed_bits = {parsed_bits[119:0], pending_nibble, nib};
            end
         end
         if (text_pos < POS_SATURATE) text_pos = text_pos + 1'b1;
      end
   endtask

   // canonical text of a 128-bit value into text_buf
   task automatic make_canonical(input logic [127:0] value, input letter_case_type letters);
      logic [3:0] nib;
      logic       upper;
      text_buf.delete();
      while (text_buf.size() < UUID_TEXT_LEN) begin
         if (is_dash_slot(POS_W'(text_buf.size()))) begin
            text_buf.push_back(CHAR_HYPHEN);
         end else begin
            nib   = value[127 -: 4];
            value = value << 4;
            upper = (letters == CASE_UPPER) ||
                    (letters == CASE_MIXED && $urandom_range(0, 1) == 1);
            if (nib < DIGIT_TEN) text_buf.push_back(CHAR_0 + 8'(nib));
            else if (upper) text_buf.push_back(CHAR_UP_A + 8'(nib) - DIGIT_TEN);
            else text_buf.push_back(CHAR_LO_A + 8'(nib) - DIGIT_TEN);
         end
      end
   endtask

   // text_buf plus its terminator onto the stimulus queue
   task automatic commit_text();
      foreach (text_buf[k]) char_queue.push_back(text_buf[k]);
      char_queue.push_back(CHAR_NUL);
   endtask

   // characters just outside the hex ranges, a hyphen, or any nonzero byte
   function automatic logic [7:0] stray_char();
      case ($urandom_range(0, 7))
         0: return CHAR_0 - 8'd1;
         1: return CHAR_9 + 8'd1;
         2: return CHAR_UP_A - 8'd1;
         3: return CHAR_UP_F + 8'd1;
         4: return CHAR_LO_A - 8'd1;
         5: return CHAR_LO_F + 8'd1;
         6: return CHAR_HYPHEN;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic letter_case_type random_letters();
      case ($urandom_range(0, 2))
         0: return CASE_LOWER;
         1: return CASE_UPPER;
         default: return CASE_MIXED;
      endcase
   endfunction

   // stimulus, then wait for the last result
   initial begin : stimulus
      logic [127:0] value;
      int           pick;
      int           texts;
      int           count;

      // all zeros, all ones in upper case, mixed case
      make_canonical('0, CASE_LOWER);
      commit_text();
      make_canonical('1, CASE_UPPER);
      commit_text();
      make_canonical(128'h00112233_44556677_8899aabb_ccddeeff, CASE_MIXED);
      commit_text();
      // empty texts back to back
      text_buf.delete();
      commit_text();
      commit_text();
      // one character short
      make_canonical(128'h01234567_89abcdef_fedcba98_76543210, CASE_LOWER);
      void'(text_buf.pop_back());
      commit_text();
      // too long, far enough to pass a 6-bit wrap
      make_canonical(128'h0f0f0f0f_f0f0f0f0_0f0f0f0f_f0f0f0f0, CASE_LOWER);
      repeat (30) text_buf.push_back(CHAR_LO_A);
      commit_text();
      // hex digit in a hyphen slot
      make_canonical('0, CASE_LOWER);
      text_buf[HYPHEN_C] = CHAR_0;
      commit_text();
      // hyphen in a digit slot
      make_canonical(128'h11111111_22222222_33333333_44444444, CASE_LOWER);
      text_buf[0] = CHAR_HYPHEN;
      commit_text();
      // non-hex letter and the top byte value
      make_canonical(128'hdeadbeef_cafef00d_12345678_9abcdef0, CASE_UPPER);
      text_buf[20] = CHAR_UP_F + 8'd1;
      commit_text();
      make_canonical(128'hdeadbeef_cafef00d_12345678_9abcdef0, CASE_LOWER);
      text_buf[1] = 8'hFF;
      commit_text();

      // random texts: mostly well formed, some damaged, some noise
      texts = 0;
      while (char_queue.size() < RANDOM_CHARS || texts < MIN_TEXTS) begin
         pick  = $urandom_range(0, 99);
         value = {$urandom, $urandom, $urandom, $urandom};
         if (pick < 8) value = '0;
         make_canonical(value, random_letters());
         if (pick < 60) begin
            // clean
         end else if (pick < 70) begin
            text_buf[$urandom_range(0, UUID_TEXT_LEN - 1)] = stray_char();
         end else if (pick < 74) begin
            text_buf[$urandom_range(0, UUID_TEXT_LEN - 1)] = CHAR_HYPHEN;
         end else if (pick < 84) begin
            count = $urandom_range(1, UUID_TEXT_LEN);
            repeat (count) void'(text_buf.pop_back());
         end else if (pick < 92) begin
            count = $urandom_range(1, 40);
            repeat (count) text_buf.push_back(8'($urandom_range(1, 255)));
         end else begin
            text_buf.delete();
            count = $urandom_range(0, 40);
            repeat (count) text_buf.push_back(8'($urandom_range(1, 255)));
         end
         commit_text();
         texts++;
      end

      do @(posedge clock); while (reset);
      while (char_queue.size() != 0 || feed_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // character driver with idle bursts
   int gap_left  = 0;
   int feed_rate = 0;
   int sent      = 0;

   always @(posedge clock) begin : driver
      logic took;
      if (reset) begin
         feed_valid <= 1'b0;
         gap_left = 0;
         clear_parse();
      end else begin
         took = feed_valid && req_ch.ready;
         if (took) begin
            parse_char(char_queue.pop_front());
            if (sent % 128 == 0) feed_rate = $urandom_range(0, 3);
            sent++;
         end
         if (feed_valid && !took) begin
            // hold the word until taken
         end else if (gap_left > 0) begin
            gap_left--;
            feed_valid <= 1'b0;
         end else if (char_queue.size() == 0) begin
            feed_valid <= 1'b0;
         end else if (char_queue.size() > QUIET_TAIL && feed_rate != 0 &&
                      $urandom_range(1, feed_rate * 4) == 1) begin
            gap_left = $urandom_range(1, 19) - 1;
            feed_valid <= 1'b0;
         end else begin
            feed_valid <= 1'b1;
            feed_char  <= char_queue[0];
         end
      end
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endfunction

   // result monitor with stall bursts
   int stall_left = 0;
   int drain_rate = 0;
   int results    = 0;

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         drain_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && drain_ready) begin
            if (expected_results.size() == 0) begin
               $error("result word with no terminator pending: status %0d", rsp_ch.status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_ch.status));
               compare_field("word0", want.word0, rsp_ch.word0);
               compare_field("word1", want.word1, rsp_ch.word1);
               compare_field("word2", want.word2, rsp_ch.word2);
               compare_field("word3", want.word3, rsp_ch.word3);
            end
            if (results % 6 == 0) drain_rate = $urandom_range(0, 3);
            results++;
         end
         if (stall_left > 0) begin
            stall_left--;
            drain_ready <= 1'b0;
         end else if (char_queue.size() > QUIET_TAIL && drain_rate != 0 &&
                      $urandom_range(1, drain_rate * 4) == 1) begin
            stall_left = $urandom_range(1, 19) - 1;
            drain_ready <= 1'b0;
         end else begin
            drain_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
`default_nettype wire
